@@ rtl/core/emcc_pkg.sv @@
// Package for the event module coincidence classifier.
// Holds item layouts, controller types, register indexes and saturating helpers.
// No dependencies; other files of the block use it by scoped names or by import.
package emcc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COINC_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_LAYER = 2'd2;

    localparam logic [31:0] COINC_THR_RST  = 32'd400000;
    localparam logic [31:0] FAST_THR_RST   = 32'd10000;
    localparam logic [1:0]  FAST_LAYER_RST = 2'd1;

    localparam int unsigned IN_TDATA_W  = 80;
    localparam int unsigned OUT_TDATA_W = 176;

    // Hit layout, event id in the lowest bits
    typedef struct packed {
        logic [23:0] energy;
        logic [1:0]  layer_id;
        logic [7:0]  module_id;
        logic [7:0]  sector_id;
        logic [31:0] event_id;
    } in_item_t;

    localparam int unsigned IN_ITEM_W = $bits(in_item_t);

    // Result layout, modules_over in the lowest bits
    typedef struct packed {
        logic [31:0] slow_count;
        logic [31:0] less_fast_count;
        logic [31:0] fast_count;
        logic [31:0] coincidences_seen;
        logic [31:0] events_seen;
        logic        table_overflow;
        logic [1:0]  fast_level;
        logic        is_coincidence;
        logic [4:0]  modules_over;
    } out_item_t;

    localparam int unsigned OUT_ITEM_W = $bits(out_item_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIT_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } emcc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic hit_wr;
        logic scan_rd;
        logic emit;
    } emcc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic have_event;
        logic same_event;
        logic scan_done;
        logic out_free;
        logic pend_flush;
    } emcc_sts_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

endpackage

@@ rtl/core/emcc_ctrl.sv @@
// Controller state machine of the coincidence classifier.
// Sequences hit update, table scan and result hand-off; uses emcc_pkg.
module emcc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_flush,
    input  emcc_pkg::emcc_sts_t sts,
    output emcc_pkg::emcc_cmd_t cmd,
    output logic                in_ready
);

    emcc_pkg::emcc_state_t state_reg;
    emcc_pkg::emcc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= emcc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            emcc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_flush)
                    begin
                        state_next = sts.have_event ? emcc_pkg::ST_SCAN : emcc_pkg::ST_IDLE;
                    end
                    else if (sts.have_event && !sts.same_event)
                    begin
                        state_next = emcc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = emcc_pkg::ST_HIT_WR;
                    end
                end
            end
            emcc_pkg::ST_HIT_WR:
            begin
                state_next = emcc_pkg::ST_IDLE;
            end
            emcc_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = emcc_pkg::ST_DRAIN;
                end
            end
            emcc_pkg::ST_DRAIN:
            begin
                state_next = emcc_pkg::ST_EMIT;
            end
            emcc_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.pend_flush ? emcc_pkg::ST_IDLE : emcc_pkg::ST_HIT_WR;
                end
            end
            default:
            begin
                state_next = emcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            emcc_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            emcc_pkg::ST_HIT_WR:
            begin
                cmd.hit_wr = 1'b1;
            end
            emcc_pkg::ST_SCAN:
            begin
                cmd.scan_rd = !sts.scan_done;
            end
            emcc_pkg::ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/emcc_datapath.sv @@
// Datapath of the coincidence classifier: module keys, energy table memory,
// scan accumulators, running counters and result register; uses emcc_pkg.
module emcc_datapath
#(
    parameter int unsigned MAX_MODULES = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  emcc_pkg::in_item_t                in_item,
    input  logic                              in_flush,
    input  logic                              cfg_wen,
    input  logic [emcc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [31:0]                       cfg_wdata,
    input  emcc_pkg::emcc_cmd_t               cmd,
    output emcc_pkg::emcc_sts_t               sts,
    input  logic                              out_ready,
    output logic                              out_valid,
    output emcc_pkg::out_item_t               out_item
);

    localparam int unsigned UW = $clog2(MAX_MODULES + 1);
    localparam int unsigned IW = $clog2(MAX_MODULES);
    localparam logic [UW-1:0] MAX_USED = UW'(MAX_MODULES);

    // Configuration
    logic [31:0] coinc_thr_reg, coinc_thr_next;
    logic [31:0] fast_thr_reg, fast_thr_next;
    logic [1:0]  fast_layer_reg, fast_layer_next;

    // Event control state
    logic [UW-1:0] used_reg, used_next;
    logic          ovf_reg, ovf_next;
    logic          have_reg, have_next;
    logic [31:0]   cur_event_reg, cur_event_next;
    logic [31:0]   ev_cnt_reg, ev_cnt_next;
    logic [31:0]   co_cnt_reg, co_cnt_next;
    logic [31:0]   fast_cnt_reg, fast_cnt_next;
    logic [31:0]   less_cnt_reg, less_cnt_next;
    logic [31:0]   slow_cnt_reg, slow_cnt_next;

    // Scan
    logic [UW-1:0] scan_idx_reg, scan_idx_next;
    logic          scan_vld_reg, scan_vld_next;
    logic [4:0]    over_reg, over_next;
    logic [1:0]    lvl_reg, lvl_next;

    logic          out_valid_reg, out_valid_next;
    emcc_pkg::out_item_t out_item_reg, out_item_next;

    // Held item
    emcc_pkg::in_item_t hold_reg;
    logic          pend_flush_reg;
    logic          new_ev_reg;
    logic          found_reg;
    logic [IW-1:0] found_idx_reg;

    // Module keys and energy table
    logic [15:0]   key_reg [MAX_MODULES];
    logic [63:0]   tbl_mem [MAX_MODULES];
    logic [63:0]   rd_data_reg;

    logic          match_any;
    logic [IW-1:0] match_idx;
    logic          same_event;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          key_wr;
    logic [UW-1:0] hit_used;
    logic [31:0]   energy32;
    logic [31:0]   fast_part;
    logic          coinc;

    assign same_event = (in_item.event_id == cur_event_reg);

    // Parallel key match over the entries in use, lowest index wins
    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = MAX_MODULES - 1; i >= 0; i--)
        begin
            if ((UW'(i) < used_reg) &&
                (key_reg[i] == {in_item.module_id, in_item.sector_id}))
            begin
                match_any = 1'b1;
                match_idx = IW'(i);
            end
        end
    end

    assign rd_en   = cmd.latch | cmd.scan_rd;
    assign rd_addr = cmd.latch ? match_idx : scan_idx_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_reg[wr_addr] <= {hold_reg.module_id, hold_reg.sector_id};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            hold_reg       <= in_item;
            pend_flush_reg <= in_flush;
            new_ev_reg     <= !(have_reg && same_event);
            found_reg      <= match_any && have_reg && same_event;
            found_idx_reg  <= match_idx;
        end
        if (cmd.emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign energy32  = {8'd0, hold_reg.energy};
    assign fast_part = (hold_reg.layer_id == fast_layer_reg) ? energy32 : 32'd0;
    assign hit_used  = new_ev_reg ? '0 : used_reg;
    assign coinc     = (over_reg == 5'd2);

    // Table write for a nonzero hit: update its entry or append one if room
    always_comb
    begin
        wr_en   = 1'b0;
        key_wr  = 1'b0;
        wr_addr = found_idx_reg;
        wr_data = {emcc_pkg::sat_add32(rd_data_reg[63:32], fast_part),
                   emcc_pkg::sat_add32(rd_data_reg[31:0], energy32)};
        if (cmd.hit_wr && (hold_reg.energy != 24'd0))
        begin
            if (found_reg)
            begin
                wr_en = 1'b1;
            end
            else if (hit_used < MAX_USED)
            begin
                wr_en   = 1'b1;
                key_wr  = 1'b1;
                wr_addr = hit_used[IW-1:0];
                wr_data = {fast_part, energy32};
            end
        end
    end

    always_comb
    begin
        coinc_thr_next  = coinc_thr_reg;
        fast_thr_next   = fast_thr_reg;
        fast_layer_next = fast_layer_reg;
        used_next       = used_reg;
        ovf_next        = ovf_reg;
        have_next       = have_reg;
        cur_event_next  = cur_event_reg;
        ev_cnt_next     = ev_cnt_reg;
        co_cnt_next     = co_cnt_reg;
        fast_cnt_next   = fast_cnt_reg;
        less_cnt_next   = less_cnt_reg;
        slow_cnt_next   = slow_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        scan_vld_next   = cmd.scan_rd;
        over_next       = over_reg;
        lvl_next        = lvl_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (cfg_wen)
        begin
            case (cfg_addr)
                emcc_pkg::CFG_COINC_THR:  coinc_thr_next  = cfg_wdata;
                emcc_pkg::CFG_FAST_THR:   fast_thr_next   = cfg_wdata;
                emcc_pkg::CFG_FAST_LAYER: fast_layer_next = cfg_wdata[1:0];
                default:                  coinc_thr_next  = coinc_thr_reg;
            endcase
        end

        if (cmd.latch)
        begin
            scan_idx_next = '0;
            over_next     = '0;
            lvl_next      = '0;
        end

        if (cmd.scan_rd)
        begin
            scan_idx_next = scan_idx_reg + UW'(1);
        end

        // Accumulate the entry read in the previous cycle
        if (scan_vld_reg && (rd_data_reg[31:0] > coinc_thr_reg))
        begin
            if (over_reg != 5'd31)
            begin
                over_next = over_reg + 5'd1;
            end
            if ((rd_data_reg[63:32] >= fast_thr_reg) && (lvl_reg != 2'd3))
            begin
                lvl_next = lvl_reg + 2'd1;
            end
        end

        if (cmd.hit_wr)
        begin
            used_next = hit_used;
            ovf_next  = new_ev_reg ? 1'b0 : ovf_reg;
            if (new_ev_reg)
            begin
                have_next      = 1'b1;
                cur_event_next = hold_reg.event_id;
                ev_cnt_next    = emcc_pkg::sat_inc32(ev_cnt_reg);
            end
            if (hold_reg.energy != 24'd0 && !found_reg)
            begin
                if (hit_used < MAX_USED)
                begin
                    used_next = hit_used + UW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            if (coinc)
            begin
                co_cnt_next = emcc_pkg::sat_inc32(co_cnt_reg);
                case (lvl_reg)
                    2'd2:    fast_cnt_next = emcc_pkg::sat_inc32(fast_cnt_reg);
                    2'd1:    less_cnt_next = emcc_pkg::sat_inc32(less_cnt_reg);
                    default: slow_cnt_next = emcc_pkg::sat_inc32(slow_cnt_reg);
                endcase
            end
            out_valid_next                  = 1'b1;
            out_item_next.modules_over      = over_reg;
            out_item_next.is_coincidence    = coinc;
            out_item_next.fast_level        = coinc ? lvl_reg : 2'd0;
            out_item_next.table_overflow    = ovf_reg;
            // A hit that closed the event has its new event counted here
            out_item_next.events_seen       = pend_flush_reg ? ev_cnt_reg
                                                             : emcc_pkg::sat_inc32(ev_cnt_reg);
            out_item_next.coincidences_seen = co_cnt_next;
            out_item_next.fast_count        = fast_cnt_next;
            out_item_next.less_fast_count   = less_cnt_next;
            out_item_next.slow_count        = slow_cnt_next;
            used_next = '0;
            ovf_next  = 1'b0;
            have_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coinc_thr_reg  <= emcc_pkg::COINC_THR_RST;
            fast_thr_reg   <= emcc_pkg::FAST_THR_RST;
            fast_layer_reg <= emcc_pkg::FAST_LAYER_RST;
            used_reg       <= '0;
            ovf_reg        <= 1'b0;
            have_reg       <= 1'b0;
            cur_event_reg  <= '0;
            ev_cnt_reg     <= '0;
            co_cnt_reg     <= '0;
            fast_cnt_reg   <= '0;
            less_cnt_reg   <= '0;
            slow_cnt_reg   <= '0;
            scan_idx_reg   <= '0;
            scan_vld_reg   <= 1'b0;
            over_reg       <= '0;
            lvl_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            coinc_thr_reg  <= coinc_thr_next;
            fast_thr_reg   <= fast_thr_next;
            fast_layer_reg <= fast_layer_next;
            used_reg       <= used_next;
            ovf_reg        <= ovf_next;
            have_reg       <= have_next;
            cur_event_reg  <= cur_event_next;
            ev_cnt_reg     <= ev_cnt_next;
            co_cnt_reg     <= co_cnt_next;
            fast_cnt_reg   <= fast_cnt_next;
            less_cnt_reg   <= less_cnt_next;
            slow_cnt_reg   <= slow_cnt_next;
            scan_idx_reg   <= scan_idx_next;
            scan_vld_reg   <= scan_vld_next;
            over_reg       <= over_next;
            lvl_reg        <= lvl_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign sts.have_event = have_reg;
    assign sts.same_event = same_event;
    assign sts.scan_done  = (scan_idx_reg == used_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.pend_flush = pend_flush_reg;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ rtl/core/event_module_coincidence_classifier_top.sv @@
// Top level of the event module coincidence classifier.
// Instantiates emcc_ctrl and emcc_datapath; uses emcc_pkg.
//
// Hits stream in one item at a time, each tagged with an event id; tuser high
// marks a flush item that closes the open event without carrying a hit. Hits
// of one event are gathered per (sector, module) in a table of MAX_MODULES
// entries, in order of first appearance, summing total and fast-layer energy
// with saturation; zero-energy hits open or join their event but add no entry,
// and hits to new modules beyond a full table are dropped and flagged. For a
// hit to the same event the accept cycle matches its key against all entries
// at once and reads the energy memory, and the next cycle writes the saturated
// sums back. A change of event id or a flush closes the event: the table
// memory is read one entry per cycle, and the result then waits for the result
// register to empty before it is loaded; a hit that closes an event then starts
// the new event with that hit. One result item is given per closed event,
// carrying the module count above the coincidence threshold, the coincidence
// flag, the fast grade, the overflow flag and the running counters after the
// update. The result register holds a result until taken while new hits of the
// next event are accepted. The user is to write configuration through
// cfg_wen/cfg_addr/cfg_wdata only while idle; the block itself does not enforce
// this.
module event_module_coincidence_classifier_top
#(
    parameter int unsigned MAX_MODULES = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: event_id[31:0], sector_id[39:32], module_id[47:40], layer_id[49:48],
    //        energy[73:50], zero pad[79:74]
    input  logic [emcc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: flush
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: modules_over[4:0], is_coincidence[5], fast_level[7:6],
    //        table_overflow[8], events_seen[40:9], coincidences_seen[72:41],
    //        fast_count[104:73], less_fast_count[136:105], slow_count[168:137],
    //        zero pad[175:169]
    output logic [emcc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wen,
    input  logic [emcc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [31:0]                         cfg_wdata
);

    emcc_pkg::emcc_cmd_t cmd;
    emcc_pkg::emcc_sts_t sts;
    emcc_pkg::in_item_t  in_item;
    emcc_pkg::out_item_t out_item;

    // Unpack the hit; the pad bits above the fields are ignored
    assign in_item = emcc_pkg::in_item_t'(s_axis_tdata[emcc_pkg::IN_ITEM_W-1:0]);

    emcc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_flush (s_axis_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    emcc_datapath
    #(
        .MAX_MODULES (MAX_MODULES)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .in_flush  (s_axis_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_item  (out_item)
    );

    // Pad the result up to whole bytes
    assign m_axis_tdata = {{(emcc_pkg::OUT_TDATA_W - emcc_pkg::OUT_ITEM_W){1'b0}}, out_item};

endmodule

@@ rtl/core/emcc_checker.sv @@
// Port-level checker for the coincidence classifier, bound to the top level.
// Depends on emcc_pkg for the result width.
module emcc_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic [emcc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Coincidence flag agrees with the module count
    a_coinc_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5] == (m_axis_tdata[4:0] == 5'd2)))
        else $error("coincidence flag disagrees with module count");

    // A fast grade only comes with a coincidence, and never above two
    a_fast_grade: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[7:6] != 2'd0)
            |-> (m_axis_tdata[5] == 1'b1) && (m_axis_tdata[7:6] != 2'd3))
        else $error("fast grade without coincidence");

endmodule

bind event_module_coincidence_classifier_top emcc_checker u_emcc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

@@ dv/emcc_tally_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the event module coincidence classifier: watches the hit, result and
// register channels, predicts each event tally and compares it field by field.
// Depends on emcc_pkg for the item layouts and register indexes.
module emcc_tally_checker
#(
    parameter int unsigned MAX_MODULES = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [emcc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [emcc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wen,
    input  logic [emcc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [31:0]                         cfg_wdata,
    output int unsigned                         results_owed,
    output int unsigned                         err_count
);
    import emcc_pkg::*;

    // Register shadow
    logic [31:0] thr_coinc;
    logic [31:0] thr_fast;
    logic [1:0]  fast_layer;

    // Module table of the open event
    logic [7:0]  mod_sector [MAX_MODULES];
    logic [7:0]  mod_id     [MAX_MODULES];
    logic [31:0] mod_total  [MAX_MODULES];
    logic [31:0] mod_fast   [MAX_MODULES];
    int unsigned mods_used;
    logic        event_open;
    logic        event_has_hits;
    logic [31:0] open_event_id;
    logic        overflow_seen;

    // Running counters
    logic [31:0] events_count;
    logic [31:0] coinc_count;
    logic [31:0] fast_grade_count;
    logic [31:0] less_fast_grade_count;
    logic [31:0] slow_grade_count;

    out_item_t tally_q [$];

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void add_deposit(input logic [7:0] sec, input logic [7:0] md,
                                        input logic [1:0] layer, input logic [23:0] e);
        logic [31:0] fpart;
        int unsigned i;
        fpart = (layer == fast_layer) ? {8'h00, e} : 32'h0;
        if (e == 24'h0)
            return;
        for (i = 0; i < mods_used; i++)
        begin
            if (mod_sector[i] == sec && mod_id[i] == md)
            begin
                mod_total[i] = sat_sum(mod_total[i], {8'h00, e});
                mod_fast[i]  = sat_sum(mod_fast[i], fpart);
                return;
            end
        end
        if (mods_used >= MAX_MODULES)
        begin
            overflow_seen = 1'b1;
            return;
        end
        mod_sector[mods_used] = sec;
        mod_id[mods_used]     = md;
        mod_total[mods_used]  = {8'h00, e};
        mod_fast[mods_used]   = fpart;
        mods_used++;
    endfunction

    // Grade and count the open event, clear it; the caller sets the counter fields
    function automatic out_item_t close_tally();
        out_item_t r;
        int unsigned over;
        int unsigned grade;
        int unsigned i;
        r = '0;
        over = 0;
        grade = 0;
        for (i = 0; i < mods_used; i++)
        begin
            if (mod_total[i] > thr_coinc)
            begin
                if (mod_fast[i] >= thr_fast)
                    grade++;
                over++;
            end
        end
        if (over != 2)
            grade = 0;
        else
        begin
            coinc_count = sat_sum(coinc_count, 32'd1);
            if (grade == 2)
                fast_grade_count = sat_sum(fast_grade_count, 32'd1);
            else if (grade == 1)
                less_fast_grade_count = sat_sum(less_fast_grade_count, 32'd1);
            else
                slow_grade_count = sat_sum(slow_grade_count, 32'd1);
        end
        r.modules_over   = (over > 31) ? 5'd31 : 5'(over);
        r.is_coincidence = (over == 2);
        r.fast_level     = 2'(grade);
        r.table_overflow = overflow_seen;
        mods_used      = 0;
        overflow_seen  = 1'b0;
        event_has_hits = 1'b0;
        event_open     = 1'b0;
        return r;
    endfunction

    function automatic void classify_item(input logic is_flush, input in_item_t hit);
        out_item_t r;
        logic      closed;
        closed = 1'b0;
        r = '0;
        if (is_flush)
        begin
            if (event_open && event_has_hits)
            begin
                r = close_tally();
                closed = 1'b1;
            end
            event_open     = 1'b0;
            event_has_hits = 1'b0;
            mods_used      = 0;
            overflow_seen  = 1'b0;
        end
        else
        begin
            if (!event_open || hit.event_id != open_event_id)
            begin
                if (event_open && event_has_hits)
                begin
                    r = close_tally();
                    closed = 1'b1;
                end
                mods_used     = 0;
                overflow_seen = 1'b0;
                events_count  = sat_sum(events_count, 32'd1);
                open_event_id = hit.event_id;
                event_open    = 1'b1;
            end
            event_has_hits = 1'b1;
            add_deposit(hit.sector_id, hit.module_id, hit.layer_id, hit.energy);
        end
        if (closed)
        begin
            // counters as they stand after this item, new event included
            r.events_seen       = events_count;
            r.coincidences_seen = coinc_count;
            r.fast_count        = fast_grade_count;
            r.less_fast_count   = less_fast_grade_count;
            r.slow_count        = slow_grade_count;
            tally_q.insert(tally_q.size(), r);
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        err_count++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (tally_q.size() == 0)
        begin
            flag_mismatch("result with no closed event", got.events_seen, 32'd0);
            return;
        end
        want = tally_q.pop_front();
        if (got.modules_over != want.modules_over)
            flag_mismatch("modules_over", 32'(got.modules_over), 32'(want.modules_over));
        if (got.is_coincidence != want.is_coincidence)
            flag_mismatch("is_coincidence", 32'(got.is_coincidence),
                          32'(want.is_coincidence));
        if (got.fast_level != want.fast_level)
            flag_mismatch("fast_level", 32'(got.fast_level), 32'(want.fast_level));
        if (got.table_overflow != want.table_overflow)
            flag_mismatch("table_overflow", 32'(got.table_overflow),
                          32'(want.table_overflow));
        if (got.events_seen != want.events_seen)
            flag_mismatch("events_seen", got.events_seen, want.events_seen);
        if (got.coincidences_seen != want.coincidences_seen)
            flag_mismatch("coincidences_seen", got.coincidences_seen,
                          want.coincidences_seen);
        if (got.fast_count != want.fast_count)
            flag_mismatch("fast_count", got.fast_count, want.fast_count);
        if (got.less_fast_count != want.less_fast_count)
            flag_mismatch("less_fast_count", got.less_fast_count, want.less_fast_count);
        if (got.slow_count != want.slow_count)
            flag_mismatch("slow_count", got.slow_count, want.slow_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_coinc             = COINC_THR_RST;
            thr_fast              = FAST_THR_RST;
            fast_layer            = FAST_LAYER_RST;
            mods_used             = 0;
            event_open            = 1'b0;
            event_has_hits        = 1'b0;
            open_event_id         = 32'h0;
            overflow_seen         = 1'b0;
            events_count          = 32'h0;
            coinc_count           = 32'h0;
            fast_grade_count      = 32'h0;
            less_fast_grade_count = 32'h0;
            slow_grade_count      = 32'h0;
            tally_q.delete();
            results_owed          = 0;
            err_count             = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_addr)
                    CFG_COINC_THR:  thr_coinc  = cfg_wdata;
                    CFG_FAST_THR:   thr_fast   = cfg_wdata;
                    CFG_FAST_LAYER: fast_layer = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_result(out_item_t'(m_axis_tdata[OUT_ITEM_W-1:0]));
            if (s_axis_tvalid && s_axis_tready)
                classify_item(s_axis_tuser, in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]));
            results_owed = tally_q.size();
        end
    end

endmodule

@@ dv/event_module_coincidence_classifier_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the event module coincidence classifier: clock, reset, hit and
// register stimulus, result back-pressure and the verdict.
// Depends on emcc_pkg, event_module_coincidence_classifier_top and emcc_tally_checker.
module event_module_coincidence_classifier_top_tb;
    import emcc_pkg::*;

    localparam int unsigned MAX_MODULES = 16;
    // Close of a full table plus the closing hit and an output stall, with margin
    localparam int unsigned SETTLE_CYCLES = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr = CFG_COINC_THR;
    logic [31:0]            cfg_wdata = 32'h0;

    int unsigned results_owed;
    int unsigned err_count;
    int unsigned items_taken;
    bit          no_idle = 1'b0;      // set for the closing stretch of the run
    int unsigned rx_hold = 0;
    logic [1:0]  fast_code = FAST_LAYER_RST;
    logic [31:0] last_event_id = 32'h0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    event_module_coincidence_classifier_top #(
        .MAX_MODULES (MAX_MODULES)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    emcc_tally_checker #(
        .MAX_MODULES (MAX_MODULES)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .results_owed  (results_owed),
        .err_count     (err_count)
    );

    // Count accepted items on the hit side; the sender waits on this, read at the
    // falling edge so it never races the handshake edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            items_taken <= 0;
        else if (s_axis_tvalid && s_axis_tready)
            items_taken <= items_taken + 1;
    end

    // Result back-pressure: stall in bursts of random length, none at the end
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready = 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 6) == 0)
        begin
            rx_hold = $urandom_range(1, 6) - 1;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = 1'b1;
    end

    // Present one item and hold it until taken. Called and returns just after a
    // falling edge; valid stays high so the next item can follow without a gap.
    task automatic push_item(input logic is_flush, input in_item_t hit);
        int unsigned target;
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tdata  = {{(IN_TDATA_W - IN_ITEM_W){1'b0}}, hit};
        s_axis_tuser  = is_flush;
        s_axis_tvalid = 1'b1;
        target = items_taken + 1;
        do
            @(negedge clk);
        while (items_taken != target);
    endtask

    task automatic put_hit(input logic [31:0] ev, input logic [7:0] sec, input logic [7:0] md,
                           input logic [1:0] layer, input logic [23:0] e);
        in_item_t hit;
        hit.event_id  = ev;
        hit.sector_id = sec;
        hit.module_id = md;
        hit.layer_id  = layer;
        hit.energy    = e;
        push_item(1'b0, hit);
        last_event_id = ev;
    endtask

    // Flush with junk in the hit fields, which the block must ignore
    task automatic put_flush();
        in_item_t junk;
        junk = in_item_t'(IN_ITEM_W'({$urandom, $urandom, $urandom}));
        push_item(1'b1, junk);
    endtask

    // Drop valid and hold until every expected result has come, then let the block
    // finish any hit still in flight
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wen   = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wen   = 1'b0;
        if (idx == CFG_FAST_LAYER)
            fast_code = val[1:0];
    endtask

    task automatic load_regs(input logic [31:0] coinc, input logic [31:0] fast,
                             input logic [1:0] layer);
        write_reg(CFG_COINC_THR, coinc);
        write_reg(CFG_FAST_THR, fast);
        write_reg(CFG_FAST_LAYER, {30'h0, layer});
    endtask

    // Spread energies around the default thresholds, with the extremes mixed in
    function automatic logic [23:0] pick_energy();
        case ($urandom_range(0, 9))
            0:       return 24'h0;
            1:       return 24'hFF_FFFF;
            2:       return 24'($urandom);
            3, 4:    return 24'($urandom_range(0, 50000));
            default: return 24'($urandom_range(100000, 600000));
        endcase
    endfunction

    // One event: a handful of modules most of the time, now and then about as many
    // as the table holds or more; mostly well-formed, sometimes cut short by a flush.
    task automatic random_event(inout int unsigned sent);
        logic [7:0]  key_sec [0:19];
        logic [7:0]  key_mod [0:19];
        int unsigned nkeys;
        int unsigned nhits;
        int unsigned h;
        int unsigned k;
        logic [31:0] ev;
        logic [1:0]  layer;
        ev = ($urandom_range(0, 9) == 0) ? last_event_id : $urandom;
        nkeys = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 4);
        for (k = 0; k < nkeys; k++)
        begin
            if (nkeys > 4)
            begin
                key_sec[k] = 8'(k);
                key_mod[k] = 8'($urandom);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                key_sec[k] = 8'($urandom);
                key_mod[k] = 8'($urandom);
            end
            else
            begin
                key_sec[k] = 8'($urandom_range(0, 3));
                key_mod[k] = 8'($urandom_range(0, 3));
            end
        end
        nhits = nkeys + $urandom_range(0, 4);
        for (h = 0; h < nhits; h++)
        begin
            k = (h < nkeys) ? h : $urandom_range(0, nkeys - 1);
            layer = $urandom_range(0, 1) ? fast_code : 2'($urandom_range(0, 3));
            put_hit(ev, key_sec[k], key_mod[k], layer, pick_energy());
            sent++;
            // broken sequence: flush part way, the rest reopens under the same id
            if ($urandom_range(0, 40) == 0)
                put_flush();
        end
        if ($urandom_range(0, 4) == 0)
        begin
            put_flush();
            if ($urandom_range(0, 2) == 0)
                put_flush();
        end
    endtask

    task automatic random_events(input int unsigned budget);
        int unsigned sent;
        sent = 0;
        while (sent < budget)
            random_event(sent);
    endtask

    initial
    begin
        logic [31:0] sat_ev;
        int unsigned h;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset thresholds (400000, 10000, layer 1).
        // Two fast modules, a zero-energy hit and a repeat deposit to one module.
        put_hit(32'h0000_0001, 8'h00, 8'h00, 2'd1, 24'hFF_FFFF);
        put_hit(32'h0000_0001, 8'hFF, 8'hFF, 2'd1, 24'd500000);
        put_hit(32'h0000_0001, 8'h03, 8'h03, 2'd2, 24'd0);
        put_hit(32'h0000_0001, 8'h00, 8'h00, 2'd0, 24'd100);
        // New id closes the fast coincidence; this one is slow
        put_hit(32'hFFFF_FFFF, 8'h01, 8'h02, 2'd2, 24'd450000);
        put_hit(32'hFFFF_FFFF, 8'h02, 8'h01, 2'd3, 24'd450000);
        // Flush closes it, a second flush finds nothing open
        put_flush();
        put_flush();
        // Same id after a flush opens a fresh event holding only a zero deposit
        put_hit(32'hFFFF_FFFF, 8'h07, 8'h07, 2'd1, 24'd0);
        // Threshold edge: raised from equal to one above counts; three modules over
        put_hit(32'h0000_0000, 8'h04, 8'h04, 2'd1, 24'd400000);
        put_hit(32'h0000_0000, 8'h05, 8'h05, 2'd1, 24'd400001);
        put_hit(32'h0000_0000, 8'h06, 8'h06, 2'd2, 24'd400001);
        put_hit(32'h0000_0000, 8'h04, 8'h04, 2'd1, 24'd1);
        // Less fast: fast energy just under and exactly at the fast threshold
        put_hit(32'hA5A5_5A5A, 8'h08, 8'h09, 2'd1, 24'd9999);
        put_hit(32'hA5A5_5A5A, 8'h08, 8'h09, 2'd2, 24'd400000);
        put_hit(32'hA5A5_5A5A, 8'h09, 8'h08, 2'd1, 24'd10000);
        put_hit(32'hA5A5_5A5A, 8'h09, 8'h08, 2'd0, 24'd390001);
        // A single module over
        put_hit(32'h0000_0002, 8'h0A, 8'h0A, 2'd1, 24'hFF_FFFF);
        put_flush();

        // Random hits under the reset values, with one full stop part way
        random_events(30);
        drain_results();
        random_events(25);
        put_flush();
        drain_results();

        // Low extremes: every loaded module counts and is fast
        load_regs(32'h0, 32'h0, 2'd0);
        random_events(30);
        put_flush();
        drain_results();

        // High extremes: only a saturated module can pass; drive one to saturation
        load_regs(32'hFFFF_FFFE, 32'hFFFF_FFFF, 2'd3);
        sat_ev = $urandom;
        for (h = 0; h < 257; h++)
        begin
            put_hit(sat_ev, 8'hF0, 8'h0F, 2'd3, 24'hFF_FFFF);
        end
        put_hit(sat_ev, 8'h0F, 8'hF0, 2'd3, 24'hFF_FFFF);
        put_flush();
        random_events(15);
        put_flush();
        drain_results();

        // Mid-range thresholds picked at random
        load_regs($urandom_range(200000, 1500000), $urandom_range(0, 600000),
                  2'($urandom_range(0, 3)));
        random_events(30);

        // Closing stretch with no idling on either side
        no_idle = 1'b1;
        random_events(20);
        put_flush();
        drain_results();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
